### rtl/bhpq_pkg.sv
// Shared types and default sizes for the binary heap priority queue.
// No dependencies; every other file of the block but bhpq_store refers to this package.
`default_nettype none

package bhpq_pkg;

    localparam int CAPACITY_DEF  = 64;
    localparam int KEY_WIDTH_DEF = 32;
    localparam int TAG_WIDTH_DEF = 16;
    localparam int CNT_WIDTH_DEF = $clog2(CAPACITY_DEF + 1);

    typedef enum logic [2:0] {
        CMD_PUSH   = 3'd0,
        CMD_POP    = 3'd1,
        CMD_TOP    = 3'd2,
        CMD_SEARCH = 3'd3,
        CMD_CLEAR  = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_CMP,
        S_UP_FIN,
        S_TOP_RD,
        S_POP_LAST,
        S_DN_L,
        S_DN_R,
        S_DN_FIN,
        S_SR_CMP,
        S_RESP
    } t_state;

    // Operation on the search walk stack.
    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
    } t_stk_op;

    // Finished result handed from the controller to the output register.
    typedef struct packed {
        logic    done;
        t_status status;
        logic    found;
    } t_res_info;

endpackage

`default_nettype wire

### rtl/bhpq_if.sv
// Valid/ready channel interfaces for the command and result beats.
// Depends on bhpq_pkg for default widths.
`default_nettype none

interface bhpq_in_if #(
    parameter int KEY_W = bhpq_pkg::KEY_WIDTH_DEF,
    parameter int TAG_W = bhpq_pkg::TAG_WIDTH_DEF
);
    logic             valid;
    logic             ready;
    logic [2:0]       command;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;

    modport source (output valid, output command, output key, output tag, input ready);
    modport sink   (input valid, input command, input key, input tag, output ready);
endinterface

interface bhpq_out_if #(
    parameter int KEY_W = bhpq_pkg::KEY_WIDTH_DEF,
    parameter int TAG_W = bhpq_pkg::TAG_WIDTH_DEF,
    parameter int CNT_W = bhpq_pkg::CNT_WIDTH_DEF
);
    logic             valid;
    logic             ready;
    logic [1:0]       status;
    logic             found;
    logic [KEY_W-1:0] result_key;
    logic [TAG_W-1:0] result_tag;
    logic [CNT_W-1:0] count;
    logic             is_empty;
    logic             is_full;

    modport source (output valid, output status, output found, output result_key,
                    output result_tag, output count, output is_empty, output is_full,
                    input ready);
    modport sink   (input valid, input status, input found, input result_key,
                    input result_tag, input count, input is_empty, input is_full,
                    output ready);
endinterface

`default_nettype wire

### rtl/bhpq_store.sv
// Entry store: simple dual port memory, one write and one registered read a cycle.
// Depends on nothing but its parameters.
`default_nettype none

module bhpq_store #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 48,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/bhpq_walk_stack.sv
// Stack of pending right subtrees for the search walk.
// Depends on bhpq_pkg for the operation struct.
`default_nettype none

module bhpq_walk_stack #(
    parameter int DEPTH = 7,
    parameter int IDX_W = 6
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire bhpq_pkg::t_stk_op i_op,
    input  wire logic [IDX_W-1:0] i_push_idx,
    output logic      [IDX_W-1:0] o_top_idx,
    output logic                  o_empty
);

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SP_W = $clog2(DEPTH + 1);

    logic [IDX_W-1:0] r_stk [DEPTH];
    logic [SP_W-1:0]  r_sp;
    logic [SP_W-1:0]  w_sp_m1;

    assign w_sp_m1 = r_sp - SP_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp <= '0;
        end else if (i_op.clear) begin
            r_sp <= '0;
        end else if (i_op.push) begin
            r_sp <= r_sp + SP_W'(1);
        end else if (i_op.pop) begin
            r_sp <= w_sp_m1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op.push && !i_op.clear) begin
            r_stk[r_sp[AW-1:0]] <= i_push_idx;
        end
    end

    assign o_top_idx = r_stk[w_sp_m1[AW-1:0]];
    assign o_empty   = (r_sp == '0);

endmodule

`default_nettype wire

### rtl/bhpq_ctrl.sv
// Command sequencer: sift up, sift down and search walk over the entry store.
// Depends on bhpq_pkg; drives bhpq_store and bhpq_walk_stack.
`default_nettype none

module bhpq_ctrl #(
    parameter int CAPACITY = bhpq_pkg::CAPACITY_DEF,
    parameter int KEY_W    = bhpq_pkg::KEY_WIDTH_DEF,
    parameter int TAG_W    = bhpq_pkg::TAG_WIDTH_DEF,
    parameter int IDX_W    = $clog2(CAPACITY),
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_key_order,
    input  wire logic                   i_cmd_valid,
    output logic                        o_cmd_ready,
    input  wire logic [2:0]             i_cmd,
    input  wire logic [KEY_W-1:0]       i_key,
    input  wire logic [TAG_W-1:0]       i_tag,
    output logic                        o_mem_we,
    output logic [IDX_W-1:0]            o_mem_waddr,
    output logic [KEY_W+TAG_W-1:0]      o_mem_wdata,
    output logic                        o_mem_re,
    output logic [IDX_W-1:0]            o_mem_raddr,
    input  wire logic [KEY_W+TAG_W-1:0] i_mem_rdata,
    output bhpq_pkg::t_stk_op           o_stk_op,
    output logic [IDX_W-1:0]            o_stk_push_idx,
    input  wire logic [IDX_W-1:0]       i_stk_top_idx,
    input  wire logic                   i_stk_empty,
    output bhpq_pkg::t_res_info         o_res,
    output logic [KEY_W-1:0]            o_res_key,
    output logic [TAG_W-1:0]            o_res_tag,
    output logic [CNT_W-1:0]            o_count,
    input  wire logic                   i_res_ready
);

    localparam int EXT_W = IDX_W + 2;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

    // True when key a belongs strictly nearer the top than key b.
    function automatic logic ranks_before(input logic [KEY_W-1:0] a,
                                          input logic [KEY_W-1:0] b,
                                          input logic             ord);
        return ord ? (a > b) : (a < b);
    endfunction

    bhpq_pkg::t_state  r_state, n_state;
    bhpq_pkg::t_status r_status, n_status;
    logic              r_found, n_found;
    logic              r_is_pop, n_is_pop;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [IDX_W-1:0]  r_i, n_i;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [TAG_W-1:0]  r_tag, n_tag;
    logic [KEY_W-1:0]  r_lc_key, n_lc_key;
    logic [TAG_W-1:0]  r_lc_tag, n_lc_tag;
    logic [KEY_W-1:0]  r_rkey, n_rkey;
    logic [TAG_W-1:0]  r_rtag, n_rtag;

    logic              w_accept;
    logic [KEY_W-1:0]  w_dkey;
    logic [TAG_W-1:0]  w_dtag;
    logic [EXT_W-1:0]  w_cnt_ext, w_lc_ext, w_rc_ext, w_ch_lc_ext;
    logic              w_lc_ok, w_rc_ok, w_ch_lc_ok;
    logic [IDX_W-1:0]  w_par, w_gpar, w_cnt_par, w_cnt_m1;
    logic              w_take_rc;
    logic [KEY_W-1:0]  w_ch_key;
    logic [TAG_W-1:0]  w_ch_tag;
    logic [IDX_W-1:0]  w_ch_idx;
    logic              w_up_swap, w_dn_swap, w_sr_prune, w_sr_hit;
    logic              w_full, w_empty;

    assign w_accept = i_cmd_valid && o_cmd_ready;
    assign w_dkey   = i_mem_rdata[KEY_W+TAG_W-1:TAG_W];
    assign w_dtag   = i_mem_rdata[TAG_W-1:0];
    assign w_full   = (r_count == CNT_FULL);
    assign w_empty  = (r_count == '0);

    // Child indices of the current slot, compared against the count.
    assign w_cnt_ext = {{(EXT_W-CNT_W){1'b0}}, r_count};
    assign w_lc_ext  = {1'b0, r_i, 1'b1};
    assign w_rc_ext  = w_lc_ext + EXT_W'(1);
    assign w_lc_ok   = (w_lc_ext < w_cnt_ext);
    assign w_rc_ok   = (w_rc_ext < w_cnt_ext);

    assign w_par     = (r_i - IDX_W'(1)) >> 1;
    assign w_gpar    = (w_par - IDX_W'(1)) >> 1;
    assign w_cnt_par = (r_count[IDX_W-1:0] - IDX_W'(1)) >> 1;
    assign w_cnt_m1  = r_count[IDX_W-1:0] - IDX_W'(1);

    // Sift down child choice: the right child wins when both rank equal.
    assign w_take_rc   = (r_state == bhpq_pkg::S_DN_R) &&
                         !ranks_before(r_lc_key, w_dkey, i_key_order);
    assign w_ch_key    = (r_state == bhpq_pkg::S_DN_R && !w_take_rc) ? r_lc_key : w_dkey;
    assign w_ch_tag    = (r_state == bhpq_pkg::S_DN_R && !w_take_rc) ? r_lc_tag : w_dtag;
    assign w_ch_idx    = w_take_rc ? w_rc_ext[IDX_W-1:0] : w_lc_ext[IDX_W-1:0];
    assign w_ch_lc_ext = {1'b0, w_ch_idx, 1'b1};
    assign w_ch_lc_ok  = (w_ch_lc_ext < w_cnt_ext);

    assign w_up_swap  = ranks_before(r_key, w_dkey, i_key_order);
    assign w_dn_swap  = ranks_before(w_ch_key, r_key, i_key_order);
    assign w_sr_prune = ranks_before(r_key, w_dkey, i_key_order);
    assign w_sr_hit   = (w_dkey == r_key);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bhpq_pkg::S_IDLE: begin
                if (w_accept) begin
                    case (i_cmd)
                        bhpq_pkg::CMD_PUSH:
                            n_state = (w_full || w_empty) ? bhpq_pkg::S_RESP
                                                          : bhpq_pkg::S_UP_CMP;
                        bhpq_pkg::CMD_POP, bhpq_pkg::CMD_TOP:
                            n_state = w_empty ? bhpq_pkg::S_RESP : bhpq_pkg::S_TOP_RD;
                        bhpq_pkg::CMD_SEARCH:
                            n_state = w_empty ? bhpq_pkg::S_RESP : bhpq_pkg::S_SR_CMP;
                        default:
                            n_state = bhpq_pkg::S_RESP;
                    endcase
                end
            end
            bhpq_pkg::S_UP_CMP: begin
                if (!w_up_swap) begin
                    n_state = bhpq_pkg::S_RESP;
                end else if (w_par == '0) begin
                    n_state = bhpq_pkg::S_UP_FIN;
                end
            end
            bhpq_pkg::S_UP_FIN: n_state = bhpq_pkg::S_RESP;
            bhpq_pkg::S_TOP_RD: begin
                if (!r_is_pop || r_count == CNT_W'(1)) begin
                    n_state = bhpq_pkg::S_RESP;
                end else begin
                    n_state = bhpq_pkg::S_POP_LAST;
                end
            end
            bhpq_pkg::S_POP_LAST: begin
                n_state = (r_count == CNT_W'(1)) ? bhpq_pkg::S_RESP : bhpq_pkg::S_DN_L;
            end
            bhpq_pkg::S_DN_L, bhpq_pkg::S_DN_R: begin
                if (r_state == bhpq_pkg::S_DN_L && w_rc_ok) begin
                    n_state = bhpq_pkg::S_DN_R;
                end else if (!w_dn_swap) begin
                    n_state = bhpq_pkg::S_RESP;
                end else if (w_ch_lc_ok) begin
                    n_state = bhpq_pkg::S_DN_L;
                end else begin
                    n_state = bhpq_pkg::S_DN_FIN;
                end
            end
            bhpq_pkg::S_DN_FIN: n_state = bhpq_pkg::S_RESP;
            bhpq_pkg::S_SR_CMP: begin
                if (!w_sr_prune && w_sr_hit) begin
                    n_state = bhpq_pkg::S_RESP;
                end else if ((w_sr_prune || !w_lc_ok) && i_stk_empty) begin
                    n_state = bhpq_pkg::S_RESP;
                end
            end
            bhpq_pkg::S_RESP: begin
                if (i_res_ready) begin
                    n_state = bhpq_pkg::S_IDLE;
                end
            end
            default: n_state = bhpq_pkg::S_IDLE;
        endcase
    end

    // Outputs and datapath next values.
    always_comb begin
        o_mem_we       = 1'b0;
        o_mem_waddr    = r_i;
        o_mem_wdata    = {r_key, r_tag};
        o_mem_re       = 1'b0;
        o_mem_raddr    = '0;
        o_stk_op       = '0;
        o_stk_push_idx = w_rc_ext[IDX_W-1:0];
        n_status       = r_status;
        n_found        = r_found;
        n_is_pop       = r_is_pop;
        n_count        = r_count;
        n_i            = r_i;
        n_key          = r_key;
        n_tag          = r_tag;
        n_lc_key       = r_lc_key;
        n_lc_tag       = r_lc_tag;
        n_rkey         = r_rkey;
        n_rtag         = r_rtag;
        unique case (r_state)
            bhpq_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_key    = i_key;
                    n_tag    = i_tag;
                    n_status = bhpq_pkg::ST_OK;
                    n_found  = 1'b0;
                    n_rkey   = '0;
                    n_rtag   = '0;
                    n_is_pop = (i_cmd == bhpq_pkg::CMD_POP);
                    case (i_cmd)
                        bhpq_pkg::CMD_PUSH: begin
                            if (w_full) begin
                                n_status = bhpq_pkg::ST_FULL;
                            end else begin
                                n_count = r_count + CNT_W'(1);
                                n_found = 1'b1;
                                n_rkey  = i_key;
                                n_rtag  = i_tag;
                                if (w_empty) begin
                                    o_mem_we    = 1'b1;
                                    o_mem_waddr = '0;
                                    o_mem_wdata = {i_key, i_tag};
                                end else begin
                                    n_i         = r_count[IDX_W-1:0];
                                    o_mem_re    = 1'b1;
                                    o_mem_raddr = w_cnt_par;
                                end
                            end
                        end
                        bhpq_pkg::CMD_POP, bhpq_pkg::CMD_TOP: begin
                            if (w_empty) begin
                                n_status = bhpq_pkg::ST_EMPTY;
                            end else begin
                                o_mem_re = 1'b1;
                            end
                        end
                        bhpq_pkg::CMD_SEARCH: begin
                            if (w_empty) begin
                                n_status = bhpq_pkg::ST_EMPTY;
                            end else begin
                                n_i            = '0;
                                o_mem_re       = 1'b1;
                                o_stk_op.clear = 1'b1;
                            end
                        end
                        bhpq_pkg::CMD_CLEAR: n_count = '0;
                        default: ;
                    endcase
                end
            end
            bhpq_pkg::S_UP_CMP: begin
                o_mem_we = 1'b1;
                if (w_up_swap) begin
                    o_mem_wdata = i_mem_rdata;
                    n_i         = w_par;
                    o_mem_re    = (w_par != '0);
                    o_mem_raddr = w_gpar;
                end
            end
            bhpq_pkg::S_UP_FIN, bhpq_pkg::S_DN_FIN: begin
                o_mem_we = 1'b1;
            end
            bhpq_pkg::S_TOP_RD: begin
                n_found = 1'b1;
                n_rkey  = w_dkey;
                n_rtag  = w_dtag;
                if (r_is_pop) begin
                    n_count = r_count - CNT_W'(1);
                    if (r_count != CNT_W'(1)) begin
                        o_mem_re    = 1'b1;
                        o_mem_raddr = w_cnt_m1;
                    end
                end
            end
            bhpq_pkg::S_POP_LAST: begin
                // The last entry becomes the sinking entry, starting at the root.
                n_key = w_dkey;
                n_tag = w_dtag;
                n_i   = '0;
                if (r_count == CNT_W'(1)) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = '0;
                    o_mem_wdata = i_mem_rdata;
                end else begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = IDX_W'(1);
                end
            end
            bhpq_pkg::S_DN_L, bhpq_pkg::S_DN_R: begin
                if (r_state == bhpq_pkg::S_DN_L) begin
                    n_lc_key = w_dkey;
                    n_lc_tag = w_dtag;
                end
                if (r_state == bhpq_pkg::S_DN_L && w_rc_ok) begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = w_rc_ext[IDX_W-1:0];
                end else begin
                    o_mem_we = 1'b1;
                    if (w_dn_swap) begin
                        o_mem_wdata = {w_ch_key, w_ch_tag};
                        n_i         = w_ch_idx;
                        o_mem_re    = w_ch_lc_ok;
                        o_mem_raddr = w_ch_lc_ext[IDX_W-1:0];
                    end
                end
            end
            bhpq_pkg::S_SR_CMP: begin
                if (!w_sr_prune && w_sr_hit) begin
                    n_found = 1'b1;
                    n_rkey  = w_dkey;
                    n_rtag  = w_dtag;
                end else if (!w_sr_prune && w_lc_ok) begin
                    // Visit the left child now; the right one waits on the stack.
                    o_stk_op.push = w_rc_ok;
                    n_i           = w_lc_ext[IDX_W-1:0];
                    o_mem_re      = 1'b1;
                    o_mem_raddr   = w_lc_ext[IDX_W-1:0];
                end else if (!i_stk_empty) begin
                    o_stk_op.pop = 1'b1;
                    n_i          = i_stk_top_idx;
                    o_mem_re     = 1'b1;
                    o_mem_raddr  = i_stk_top_idx;
                end
            end
            bhpq_pkg::S_RESP: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bhpq_pkg::S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_found  <= n_found;
        r_is_pop <= n_is_pop;
        r_i      <= n_i;
        r_key    <= n_key;
        r_tag    <= n_tag;
        r_lc_key <= n_lc_key;
        r_lc_tag <= n_lc_tag;
        r_rkey   <= n_rkey;
        r_rtag   <= n_rtag;
    end

    assign o_cmd_ready  = (r_state == bhpq_pkg::S_IDLE);
    assign o_res.done   = (r_state == bhpq_pkg::S_RESP);
    assign o_res.status = r_status;
    assign o_res.found  = r_found;
    assign o_res_key    = r_rkey;
    assign o_res_tag    = r_rtag;
    assign o_count      = r_count;

endmodule

`default_nettype wire

### rtl/binary_heap_priority_queue.sv
// Binary heap priority queue. A push climbs the tree level by level, a pop sinks the
// moved last entry level by level, and a search walks the tree node by node; a push into an
// empty or full heap, any read of an empty heap and a clear go straight to the response.
// The finished result passes through an output register that takes it when empty or when its
// beat is taken. One command is in work at a time; the sift loops run over the single-read-port
// store. Reset zeroes the count and selects smallest-first; store not cleared.
`default_nettype none

module binary_heap_priority_queue #(
    parameter int CAPACITY  = bhpq_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH = bhpq_pkg::KEY_WIDTH_DEF,
    parameter int TAG_WIDTH = bhpq_pkg::TAG_WIDTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bhpq_in_if.sink    i_cmd_ch,
    bhpq_out_if.source o_res_ch,
    input  wire logic  i_cfg_we,
    input  wire logic  i_cfg_wdata
);

    // Slot index width and the width of the entry count, which reaches CAPACITY.
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    // The walk stack only ever holds one pending right subtree per tree level.
    localparam int STK_D = IDX_W + 1;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

    // Key order register: 0 puts the smallest key on top, 1 the largest.
    logic r_key_order;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_order <= 1'b0;
        end else if (i_cfg_we) begin
            r_key_order <= i_cfg_wdata;
        end
    end

    // Store and stack connections.
    logic                       w_mem_we, w_mem_re;
    logic [IDX_W-1:0]           w_mem_waddr, w_mem_raddr;
    logic [KEY_WIDTH+TAG_WIDTH-1:0] w_mem_wdata, w_mem_rdata;
    bhpq_pkg::t_stk_op          w_stk_op;
    logic [IDX_W-1:0]           w_stk_push_idx, w_stk_top_idx;
    logic                       w_stk_empty;

    // Finished result from the sequencer.
    bhpq_pkg::t_res_info        w_res;
    logic [KEY_WIDTH-1:0]       w_res_key;
    logic [TAG_WIDTH-1:0]       w_res_tag;
    logic [CNT_W-1:0]           w_count;
    logic                       w_res_ready;
    logic                       w_cmd_ready;

    bhpq_store #(
        .DEPTH (CAPACITY),
        .WIDTH (KEY_WIDTH + TAG_WIDTH),
        .AW    (IDX_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_mem_re),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    bhpq_walk_stack #(
        .DEPTH (STK_D),
        .IDX_W (IDX_W)
    ) u_stack (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (w_stk_op),
        .i_push_idx (w_stk_push_idx),
        .o_top_idx  (w_stk_top_idx),
        .o_empty    (w_stk_empty)
    );

    bhpq_ctrl #(
        .CAPACITY (CAPACITY),
        .KEY_W    (KEY_WIDTH),
        .TAG_W    (TAG_WIDTH),
        .IDX_W    (IDX_W),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_key_order    (r_key_order),
        .i_cmd_valid    (i_cmd_ch.valid),
        .o_cmd_ready    (w_cmd_ready),
        .i_cmd          (i_cmd_ch.command),
        .i_key          (i_cmd_ch.key),
        .i_tag          (i_cmd_ch.tag),
        .o_mem_we       (w_mem_we),
        .o_mem_waddr    (w_mem_waddr),
        .o_mem_wdata    (w_mem_wdata),
        .o_mem_re       (w_mem_re),
        .o_mem_raddr    (w_mem_raddr),
        .i_mem_rdata    (w_mem_rdata),
        .o_stk_op       (w_stk_op),
        .o_stk_push_idx (w_stk_push_idx),
        .i_stk_top_idx  (w_stk_top_idx),
        .i_stk_empty    (w_stk_empty),
        .o_res          (w_res),
        .o_res_key      (w_res_key),
        .o_res_tag      (w_res_tag),
        .o_count        (w_count),
        .i_res_ready    (w_res_ready)
    );

    assign i_cmd_ch.ready = w_cmd_ready;

    // Output register. A finished result moves in when the register is empty or
    // its beat is taken in the same cycle, so the sequencer can return to idle and
    // accept the next command while a result still waits downstream.
    logic                 r_o_valid;
    bhpq_pkg::t_status    r_o_status;
    logic                 r_o_found;
    logic [KEY_WIDTH-1:0] r_o_key;
    logic [TAG_WIDTH-1:0] r_o_tag;
    logic [CNT_W-1:0]     r_o_count;
    logic                 w_load;

    assign w_res_ready = !r_o_valid || o_res_ch.ready;
    assign w_load      = w_res.done && w_res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_load) begin
            r_o_valid <= 1'b1;
        end else if (o_res_ch.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_status <= w_res.status;
            r_o_found  <= w_res.found;
            r_o_key    <= w_res_key;
            r_o_tag    <= w_res_tag;
            r_o_count  <= w_count;
        end
    end

    assign o_res_ch.valid      = r_o_valid;
    assign o_res_ch.status     = r_o_status;
    assign o_res_ch.found      = r_o_found;
    assign o_res_ch.result_key = r_o_key;
    assign o_res_ch.result_tag = r_o_tag;
    assign o_res_ch.count      = r_o_count;
    assign o_res_ch.is_empty   = (r_o_count == '0);
    assign o_res_ch.is_full    = (r_o_count == CNT_FULL);

    // The sequencer works on one command at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd_ch.valid && i_cmd_ch.ready) |=> !i_cmd_ch.ready)
        else $error("command accepted while another is in work");

    // A finished result always reaches the output register.
    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res.done && w_res_ready) |=> o_res_ch.valid)
        else $error("finished result was not registered");

    // Fields without a match read as zero.
    a_no_match_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_ch.valid && !o_res_ch.found) |->
            (o_res_ch.result_key == '0 && o_res_ch.result_tag == '0))
        else $error("result fields not zero without a match");

    // A rejected push only happens on a full heap, an empty status on an empty one.
    a_status_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_ch.valid |->
            ((o_res_ch.status != bhpq_pkg::ST_FULL || o_res_ch.is_full) &&
             (o_res_ch.status != bhpq_pkg::ST_EMPTY || o_res_ch.is_empty)))
        else $error("status disagrees with the count flags");

endmodule

`default_nettype wire
